// ===== hw/rtl/swpt_pkg.sv =====
`timescale 1ns / 1ps

package swpt_pkg;

    // width of the free-running time base and of all durations
    localparam int TIME_BITS = 32;
    localparam int COUNT_BITS = 32;
    localparam int CFG_DATA_BITS = 32;
    localparam int CFG_IDX_BITS = 3;

    // operation codes carried by an input transaction
    typedef enum logic [1:0] {
        OP_STEP  = 2'd0,
        OP_START = 2'd1,
        OP_STOP  = 2'd2
    } t_op;

    // configuration register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_START_LEVEL = 3'd0,
        REG_DELAY_TIME  = 3'd1,
        REG_LOW_TIME    = 3'd2,
        REG_HIGH_TIME   = 3'd3,
        REG_PHASE_COUNT = 3'd4
    } t_reg_idx;

    // generator mode
    typedef enum logic [2:0] {
        MODE_IDLE  = 3'b001,
        MODE_SETUP = 3'b010,
        MODE_RUN   = 3'b100
    } t_mode;

    // input transaction payload
    typedef struct packed {
        logic [1:0]           op;
        logic [TIME_BITS-1:0] now_time;
    } t_in;

    // result transaction payload
    typedef struct packed {
        logic line_level;
        logic toggled;
        logic idle;
    } t_out;

    // live configuration handed to the generator core
    typedef struct packed {
        logic                  start_level;
        logic [TIME_BITS-1:0]  delay_time;
        logic [TIME_BITS-1:0]  low_time;
        logic [TIME_BITS-1:0]  high_time;
        logic [COUNT_BITS-1:0] phase_count;
    } t_cfg;

endpackage

// ===== hw/rtl/square_wave_pulse_train.sv =====
`timescale 1ns / 1ps

// Square wave pulse train generator. Each input transaction (step, start or
// stop) gives exactly one result transaction holding the line level, a toggle
// flag and the idle flag. A transaction is taken into an input register; once
// the output register is free, the generator state and the result are worked
// out in a single pass (one time compare plus the deadline adds), and the
// result sits in an output register until the sink takes it. One transaction
// per clock is sustained when the output is not stalled. Configuration
// registers are written through their own port, which is always ready; write
// them only while the generator is idle.

module square_wave_pulse_train (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  swpt_pkg::t_in                      i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output swpt_pkg::t_out                     o_out_data,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [swpt_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [swpt_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);
    import swpt_pkg::*;

    t_cfg w_cfg;
    t_in  r_in_data;
    logic r_in_valid;
    t_out w_result;
    t_out r_out_data;
    logic r_out_valid;
    logic w_out_free;
    logic w_fire;
    logic w_in_take;

    swpt_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // pipeline handshake
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_fire     = r_in_valid && w_out_free;
    assign o_in_stall = r_in_valid && !w_out_free;
    assign w_in_take  = i_in_valid && !o_in_stall;

    swpt_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_item   (r_in_data),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_data <= i_in_data;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_data <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== hw/rtl/swpt_cfg.sv =====
`timescale 1ns / 1ps

module swpt_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [swpt_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [swpt_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    output swpt_pkg::t_cfg                     o_cfg
);
    import swpt_pkg::*;

    t_cfg r_cfg;
    logic w_wr;

    // register file is always able to take a write
    assign o_cfg_ready = 1'b1;
    assign w_wr = i_cfg_valid && o_cfg_ready;
    assign o_cfg = r_cfg;

    // register writes by index, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_level <= 1'b1;
            r_cfg.delay_time  <= '0;
            r_cfg.low_time    <= '0;
            r_cfg.high_time   <= '0;
            r_cfg.phase_count <= COUNT_BITS'(2);
        end else if (w_wr) begin
            case (i_cfg_index)
                REG_START_LEVEL: begin
                    r_cfg.start_level <= i_cfg_data[0];
                end
                REG_DELAY_TIME: begin
                    r_cfg.delay_time <= i_cfg_data[TIME_BITS-1:0];
                end
                REG_LOW_TIME: begin
                    r_cfg.low_time <= i_cfg_data[TIME_BITS-1:0];
                end
                REG_HIGH_TIME: begin
                    r_cfg.high_time <= i_cfg_data[TIME_BITS-1:0];
                end
                REG_PHASE_COUNT: begin
                    r_cfg.phase_count <= i_cfg_data[COUNT_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/swpt_core.sv =====
`timescale 1ns / 1ps

module swpt_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_fire,
    input  swpt_pkg::t_in  i_item,
    input  swpt_pkg::t_cfg i_cfg,
    output swpt_pkg::t_out o_result
);
    import swpt_pkg::*;

    t_mode                 r_mode, n_mode;
    logic                  r_wave, n_wave;
    logic                  r_drv, n_drv;
    logic [COUNT_BITS-1:0] r_left, n_left;
    logic [TIME_BITS-1:0]  r_deadline, n_deadline;
    logic                  w_toggled;

    logic [TIME_BITS:0]    w_delay_sum;
    logic [TIME_BITS-1:0]  w_high_sum;
    logic [TIME_BITS-1:0]  w_low_sum;
    logic                  w_delay_zero;
    logic                  w_setup_hit;
    logic                  w_run_hit;
    logic                  w_wave_a;

    // deadline candidates, all computed in parallel from now
    assign w_delay_sum = {1'b0, i_item.now_time} + {1'b0, i_cfg.delay_time};
    assign w_high_sum  = i_item.now_time + i_cfg.high_time;
    assign w_low_sum   = i_item.now_time + i_cfg.low_time;
    assign w_delay_zero = (i_cfg.delay_time == '0);

    // first step after start: deadline reached at once when the delay is zero,
    // otherwise only when now plus delay wrapped past the top
    assign w_setup_hit = w_delay_zero || w_delay_sum[TIME_BITS];
    assign w_run_hit   = (i_item.now_time >= r_deadline);

    // next state and result
    always_comb begin
        n_mode     = r_mode;
        n_wave     = r_wave;
        n_drv      = r_drv;
        n_left     = r_left;
        n_deadline = r_deadline;
        w_toggled  = 1'b0;
        w_wave_a   = r_wave;
        case (i_item.op)
            OP_START: begin
                n_left = i_cfg.phase_count;
                n_wave = i_cfg.start_level;
                n_mode = MODE_SETUP;
            end
            OP_STOP: begin
                n_drv  = r_left[0] ? i_cfg.start_level : ~i_cfg.start_level;
                n_mode = MODE_IDLE;
            end
            OP_STEP: begin
                if (r_mode == MODE_SETUP) begin
                    // opposite level, held for the delay
                    w_wave_a = ~i_cfg.start_level;
                    n_wave   = w_wave_a;
                    n_mode   = MODE_RUN;
                    if (w_delay_zero) begin
                        n_deadline = '0;
                    end else begin
                        n_drv      = w_wave_a;
                        n_deadline = w_delay_sum[TIME_BITS-1:0];
                    end
                end
                if ((r_mode == MODE_SETUP && w_setup_hit) ||
                    (r_mode == MODE_RUN && w_run_hit)) begin
                    // phase toggle
                    if (r_left != '0) begin
                        n_left = r_left - COUNT_BITS'(1);
                        if (r_left == COUNT_BITS'(1)) begin
                            n_mode = MODE_IDLE;
                        end
                    end
                    n_wave     = ~w_wave_a;
                    n_drv      = ~w_wave_a;
                    n_deadline = w_wave_a ? w_low_sum : w_high_sum;
                    w_toggled  = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_result.line_level = n_drv;
    assign o_result.toggled    = w_toggled;
    assign o_result.idle       = (n_mode == MODE_IDLE);

    // generator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_IDLE;
            r_wave     <= 1'b0;
            r_drv      <= 1'b0;
            r_left     <= '0;
            r_deadline <= '0;
        end else if (i_fire) begin
            r_mode     <= n_mode;
            r_wave     <= n_wave;
            r_drv      <= n_drv;
            r_left     <= n_left;
            r_deadline <= n_deadline;
        end
    end

`ifndef NO_ASSERTIONS
    // a toggle never comes out of an idle generator
    a_no_toggle_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && w_toggled) |-> (r_mode != MODE_IDLE))
        else $error("toggle produced while idle");

    // a start transaction always leaves the generator in setup
    a_start_setup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_item.op == OP_START) |=> (r_mode == MODE_SETUP))
        else $error("start did not arm setup");

    // a running generator only finishes on its last phase
    a_finish_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_item.op == OP_STEP && r_mode == MODE_RUN && n_mode == MODE_IDLE)
        |-> (r_left == COUNT_BITS'(1) && w_toggled))
        else $error("run ended before last phase");

    // the toggled level is what the line shows
    a_toggle_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && w_toggled) |=> (r_drv == r_wave))
        else $error("line level differs from wave after toggle");
`endif

endmodule
